FILE: rtl/core/sdts_pkg.sv
// Package for the sorted date table: sizes, codes, beat types and search cell state.
package sdts_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int NCELL       = CNT_W;

  localparam int FUNC_W   = 3;
  localparam int DATE_W   = 27;
  localparam int INDEX_W  = 12;
  localparam int VALUE_W  = 28;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = 13;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_BYINDEX = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_FIND    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_NEAREST = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_DUP  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_READ,
    ST_SHIFT
  } fsm_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [DATE_W-1:0]  date_in;
    logic [INDEX_W-1:0] index_in;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value_out;
    logic [STATUS_W-1:0]       status;
    logic [ENTRY_W-1:0]        entry_count;
  } out_item_t;

  // One bisection step in flight: range [lo, hi), probe point mid, match seen.
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] lo;
    logic [CNT_W-1:0] hi;
    logic [CNT_W-1:0] mid;
    logic             eq;
  } srch_t;

endpackage

FILE: rtl/core/sdts_ram.sv
// Generic simple dual-port RAM with registered read.
module sdts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/sdts_cell.sv
// Search cell: holds one bisection step and hands the narrowed range to the next cell.
module sdts_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  sdts_pkg::srch_t            load,
  input  logic [sdts_pkg::DATE_W-1:0] key,
  input  logic                       upper,
  input  logic [sdts_pkg::DATE_W-1:0] rdata,
  output sdts_pkg::srch_t            step
);
  import sdts_pkg::*;

  srch_t            st;
  logic             less;
  logic [CNT_W-1:0] lo_n;
  logic [CNT_W-1:0] hi_n;
  logic             eq_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.valid <= 1'b0;
    end else begin
      st <= load;
    end
  end

  // rdata holds the entry at st.mid, read when this cell was loaded
  always_comb begin
    less = upper ? (rdata <= key) : (rdata < key);
    lo_n = st.lo;
    hi_n = st.hi;
    eq_n = st.eq;
    if (st.lo < st.hi) begin
      if (less) begin
        lo_n = st.mid + CNT_W'(1);
      end else begin
        hi_n = st.mid;
        eq_n = (rdata == key);
      end
    end
    step.valid = st.valid;
    step.lo    = lo_n;
    step.hi    = hi_n;
    step.mid   = lo_n + ((hi_n - lo_n) >> 1);
    step.eq    = eq_n;
  end

endmodule

FILE: rtl/core/sorted_date_table_search_top.sv
// Top level of the sorted date table: command sequencer, date RAM and search cell chain.
//
// Commands enter on cmd, accepted when start is high and busy is low. Each command
// gives exactly one result beat on result, marked by done for one cycle; the
// receiver cannot stall it. A new command may be accepted in the cycle done is high.
// Command flow, with N = NCELL (13 at 4096 entries) search cells:
//   clear, unused codes, nearest on an empty table, out-of-range read: answered from idle
//   date by index: one RAM read in the read state
//   index by date, nearest index: one RAM read per cell through the N cells
//   insert: ends after the search when duplicate or full; else the upper entries move up
//   one entry per cycle through the RAM ports, then the date is written at its position.
// busy is high while the sequencer is out of idle and falls in the cycle done rises;
// commands answered from idle never raise it. Reset empties the table at once (count to
// zero); no clearing pass is needed since entries at or beyond the count are never used.
module sorted_date_table_search_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  sdts_pkg::in_item_t  cmd,
  output logic                done,
  output sdts_pkg::out_item_t result
);
  import sdts_pkg::*;

  fsm_t               state;
  fsm_t               state_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [DATE_W-1:0]  key;
  logic [DATE_W-1:0]  key_next;
  logic               upper;
  logic               upper_next;
  logic [FUNC_W-1:0]  func_r;
  logic [FUNC_W-1:0]  func_next;
  logic [CNT_W-1:0]   pos;
  logic [CNT_W-1:0]   pos_next;
  logic [CNT_W-1:0]   j;
  logic [CNT_W-1:0]   j_next;
  logic [CNT_W-1:0]   pdst;
  logic [CNT_W-1:0]   pdst_next;
  logic               pend;
  logic               pend_next;
  logic               done_next;
  out_item_t          result_next;

  logic [VALUE_W-1:0]  res_val;
  logic [STATUS_W-1:0] res_stat;

  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [DATE_W-1:0]  wdata;
  logic [ADDR_W-1:0]  raddr;
  logic [DATE_W-1:0]  rdata;

  srch_t              load0;
  srch_t              steps [NCELL];
  srch_t              last;
  logic [ADDR_W-1:0]  cell_addr;

  logic               is_search;
  logic               idx_ok;
  logic               hit;
  logic               full;
  logic               shift_more;

  sdts_ram #(
    .WIDTH(DATE_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    sdts_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .load (k == 0 ? load0 : steps[(k == 0) ? 0 : k - 1]),
      .key  (key),
      .upper(upper),
      .rdata(rdata),
      .step (steps[k])
    );
  end

  assign last = steps[NCELL-1];

  always_comb begin
    cell_addr = '0;
    for (int k = 0; k < NCELL; k++) begin
      if (steps[k].valid) begin
        cell_addr = cell_addr | ADDR_W'(steps[k].mid);
      end
    end
  end

  assign is_search  = (cmd.func == FUNC_INSERT) || (cmd.func == FUNC_FIND) ||
                      ((cmd.func == FUNC_NEAREST) && (count != '0));
  assign idx_ok     = 32'(cmd.index_in) < 32'(count);
  assign hit        = (last.lo < count) && last.eq;
  assign full       = (count == CNT_W'(TABLE_DEPTH));
  assign shift_more = (j > pos);

  assign busy = (state != ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (is_search) begin
            state_next = ST_SEARCH;
          end else if ((cmd.func == FUNC_BYINDEX) && idx_ok) begin
            state_next = ST_READ;
          end
        end
      end
      ST_SEARCH: begin
        if (last.valid) begin
          if ((func_r == FUNC_INSERT) && !hit && !full) begin
            state_next = ST_SHIFT;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      ST_SHIFT: begin
        if (!shift_more && !pend) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    load0      = '0;
    raddr      = cell_addr;
    we         = 1'b0;
    waddr      = ADDR_W'(pdst);
    wdata      = rdata;
    key_next   = key;
    upper_next = upper;
    func_next  = func_r;
    count_next = count;
    pos_next   = pos;
    j_next     = j;
    pdst_next  = pdst;
    pend_next  = 1'b0;
    done_next  = 1'b0;
    res_val    = '1;
    res_stat   = STAT_MISS;
    case (state)
      ST_IDLE: begin
        if (start) begin
          key_next  = cmd.date_in;
          func_next = cmd.func;
          if (is_search) begin
            load0.valid = 1'b1;
            load0.lo    = '0;
            load0.hi    = count;
            load0.mid   = count >> 1;
            load0.eq    = 1'b0;
            raddr       = ADDR_W'(count >> 1);
            upper_next  = (cmd.func == FUNC_NEAREST);
          end else if (cmd.func == FUNC_CLEAR) begin
            count_next = '0;
            res_val    = '0;
            res_stat   = STAT_OK;
            done_next  = 1'b1;
          end else if ((cmd.func == FUNC_BYINDEX) && idx_ok) begin
            raddr = ADDR_W'(cmd.index_in);
          end else begin
            done_next = 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        if (last.valid) begin
          pos_next = last.lo;
          j_next   = count;
          case (func_r)
            FUNC_INSERT: begin
              if (hit) begin
                res_val   = VALUE_W'(last.lo);
                res_stat  = STAT_DUP;
                done_next = 1'b1;
              end else if (full) begin
                res_stat  = STAT_FULL;
                done_next = 1'b1;
              end
            end
            FUNC_FIND: begin
              if (hit) begin
                res_val  = VALUE_W'(last.lo);
                res_stat = STAT_OK;
              end
              done_next = 1'b1;
            end
            default: begin
              // nearest: floor of the upper bound, clamped to the first entry
              res_val   = (last.lo == '0) ? '0 : VALUE_W'(last.lo - CNT_W'(1));
              res_stat  = STAT_OK;
              done_next = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        res_val   = VALUE_W'(rdata);
        res_stat  = STAT_OK;
        done_next = 1'b1;
      end
      ST_SHIFT: begin
        if (pend) begin
          we = 1'b1;
        end
        if (shift_more) begin
          raddr     = ADDR_W'(j - CNT_W'(1));
          pend_next = 1'b1;
          pdst_next = j;
          j_next    = j - CNT_W'(1);
        end else if (!pend) begin
          we         = 1'b1;
          waddr      = ADDR_W'(pos);
          wdata      = key;
          count_next = count + CNT_W'(1);
          res_val    = VALUE_W'(pos);
          res_stat   = STAT_OK;
          done_next  = 1'b1;
        end
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
    result_next.value_out   = res_val;
    result_next.status      = res_stat;
    result_next.entry_count = ENTRY_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    key    <= key_next;
    upper  <= upper_next;
    func_r <= func_next;
    pos    <= pos_next;
    j      <= j_next;
    pdst   <= pdst_next;
    if (done_next) begin
      result <= result_next;
    end
  end

endmodule

FILE: sim/tb_top.sv
// Testbench for the sorted date table: directed, bulk-fill and random command beats.
`timescale 1ns / 1ps

module tb_top;
  import sdts_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;
  localparam logic [DATE_W-1:0] DATE_TOP      = '1;
  localparam int FILL_STEP    = (1 << DATE_W) / TABLE_DEPTH;
  localparam int FILL_COUNT   = 300;
  localparam int PHASE_ITEMS  = 130;
  localparam int CLEAR_AT     = 160;
  localparam int REPORT_LIMIT = 50;

  // Shadow of the date table; predicts each result and checks the done beats.
  class date_table_ledger;
    logic [DATE_W-1:0] dates [TABLE_DEPTH];
    int unsigned       held;
    out_item_t         results_due [$];
    int unsigned       faults;

    function int unsigned first_not_below(logic [DATE_W-1:0] key);
      int unsigned lo, hi, mid;
      lo = 0;
      hi = held;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (dates[mid] < key) lo = mid + 1;
        else hi = mid;
      end
      return lo;
    endfunction

    function int unsigned floor_pos(logic [DATE_W-1:0] key);
      int unsigned lo, hi, mid;
      hi = held - 1;
      if (hi == 0) return 0;
      if (key >= dates[hi]) return hi;
      lo = 0;
      while (hi - lo > 1) begin
        mid = (lo + hi) / 2;
        if (key < dates[mid]) hi = mid;
        else lo = mid;
      end
      return lo;
    endfunction

    function void take_cmd(in_item_t c);
      out_item_t   r;
      int unsigned pos, k;
      r.value_out = '1;
      r.status    = STAT_MISS;
      case (c.func)
        FUNC_CLEAR: begin
          held        = 0;
          r.value_out = '0;
          r.status    = STAT_OK;
        end
        FUNC_INSERT: begin
          pos = first_not_below(c.date_in);
          if (pos < held && dates[pos] == c.date_in) begin
            r.value_out = VALUE_W'(pos);
            r.status    = STAT_DUP;
          end else if (held >= TABLE_DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            for (k = held; k > pos; k--) dates[k] = dates[k-1];
            dates[pos]  = c.date_in;
            held++;
            r.value_out = VALUE_W'(pos);
            r.status    = STAT_OK;
          end
        end
        FUNC_BYINDEX: begin
          if (c.index_in < held) begin
            r.value_out = VALUE_W'(dates[c.index_in]);
            r.status    = STAT_OK;
          end
        end
        FUNC_FIND: begin
          pos = first_not_below(c.date_in);
          if (pos < held && dates[pos] == c.date_in) begin
            r.value_out = VALUE_W'(pos);
            r.status    = STAT_OK;
          end
        end
        FUNC_NEAREST: begin
          if (held != 0) begin
            r.value_out = VALUE_W'(floor_pos(c.date_in));
            r.status    = STAT_OK;
          end
        end
        default: ;
      endcase
      r.entry_count = ENTRY_W'(held);
      results_due = {results_due, r};
    endfunction

    function void flag(string field, logic signed [31:0] want, logic signed [31:0] got);
      faults++;
      if (faults <= REPORT_LIMIT)
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (results_due.size() == 0) begin
        faults++;
        if (faults <= REPORT_LIMIT)
          $display("%0t ns: unexpected result beat, expected none, got value %0d status %0d",
                   $time, got.value_out, got.status);
        return;
      end
      want = results_due.pop_front();
      if (got.value_out !== want.value_out) flag("value_out", want.value_out, got.value_out);
      if (got.status !== want.status) flag("status", want.status, got.status);
      if (got.entry_count !== want.entry_count)
        flag("entry_count", want.entry_count, got.entry_count);
    endfunction
  endclass

  logic      clk   = 1'b0;
  logic      rst   = 1'b1;
  logic      start = 1'b0;
  in_item_t  cmd   = '0;
  logic      busy;
  logic      done;
  out_item_t result;

  date_table_ledger ledger = new();

  int idle_pct [4] = '{0, 69, 0, 12};

  sorted_date_table_search_top dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (done) ledger.check_result(result);
      if (start && !busy) ledger.take_cmd(cmd);
    end
  end

  function automatic in_item_t mk(logic [FUNC_W-1:0] f, logic [DATE_W-1:0] d,
                                  logic [INDEX_W-1:0] i);
    in_item_t c;
    c.func     = f;
    c.date_in  = d;
    c.index_in = i;
    return c;
  endfunction

  function automatic logic [DATE_W-1:0] pick_date();
    int unsigned       r;
    logic [DATE_W-1:0] d;
    r = $urandom_range(99);
    if (ledger.held != 0 && r < 55) begin
      d = ledger.dates[$urandom_range(ledger.held - 1)];
      if (r < 40) return d;
      return $urandom_range(1) ? d + 1'b1 : d - 1'b1;
    end
    if (r < 85)
      return DATE_W'($urandom_range(2099, 1900) * 10000 + $urandom_range(12, 1) * 100 +
                     $urandom_range(31, 1));
    return DATE_W'($urandom);
  endfunction

  function automatic in_item_t random_cmd();
    in_item_t    c;
    int unsigned r;
    r         = $urandom_range(99);
    c.date_in = pick_date();
    if (ledger.held != 0 && $urandom_range(9) < 7)
      c.index_in = INDEX_W'($urandom_range(ledger.held - 1));
    else
      c.index_in = INDEX_W'($urandom);
    if (ledger.held >= CLEAR_AT || r < 1) c.func = FUNC_CLEAR;
    else if (r < 3) c.func = FUNC_W'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
    else if (r < 43) c.func = FUNC_INSERT;
    else if (r < 58) c.func = FUNC_BYINDEX;
    else if (r < 78) c.func = FUNC_FIND;
    else c.func = FUNC_NEAREST;
    return c;
  endfunction

  // Holds start until the beat is taken; returns at the accepting edge.
  task automatic issue(in_item_t c);
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
  endtask

  task automatic gap(int pct);
    if (pct != 0 && $urandom_range(99) < pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (ledger.results_due.size() != 0);
  endtask

  initial begin
    #100_000_000;
    $display("** sorted_date_table_search_top: FAILED **");
    $finish;
  end

  initial begin
    int f, k, p, n;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty table, spare codes, small table corner cases
    issue(mk(FUNC_NEAREST, 27'd20240101, '0));
    issue(mk(FUNC_FIND, 27'd20240101, '0));
    issue(mk(FUNC_BYINDEX, '0, '0));
    for (f = FUNC_SPARE_LO; f <= FUNC_SPARE_HI; f++) issue(mk(FUNC_W'(f), DATE_TOP, '1));
    issue(mk(FUNC_INSERT, 27'd20240315, '0));
    issue(mk(FUNC_NEAREST, '0, '0));
    issue(mk(FUNC_INSERT, '0, '0));
    issue(mk(FUNC_INSERT, DATE_TOP, '0));
    issue(mk(FUNC_INSERT, 27'd20240315, '0));
    issue(mk(FUNC_FIND, 27'd20240315, '0));
    issue(mk(FUNC_FIND, 27'd20240316, '0));
    issue(mk(FUNC_NEAREST, DATE_TOP, '0));
    issue(mk(FUNC_NEAREST, 27'd20240314, '0));
    issue(mk(FUNC_NEAREST, 27'd20240400, '0));
    issue(mk(FUNC_BYINDEX, '0, 12'd2));
    issue(mk(FUNC_BYINDEX, '0, '1));
    issue(mk(FUNC_CLEAR, DATE_TOP, '1));
    issue(mk(FUNC_INSERT, 27'd19991231, '0));
    issue(mk(FUNC_INSERT, 27'd20000101, '0));
    issue(mk(FUNC_NEAREST, 27'd19000101, '0));
    issue(mk(FUNC_CLEAR, '0, '0));
    drain();

    // bulk fill with ascending dates, then probe the filled table
    for (k = 0; k < FILL_COUNT; k++) begin
      issue(mk(FUNC_INSERT, DATE_W'(k * FILL_STEP + $urandom_range(FILL_STEP - 1)), '0));
      gap(12);
    end
    drain();
    issue(mk(FUNC_INSERT, ledger.dates[$urandom_range(FILL_COUNT - 1)], '0));
    for (k = 0; k < 3; k++) issue(mk(FUNC_INSERT, DATE_W'($urandom), '0));
    issue(mk(FUNC_BYINDEX, '0, INDEX_W'(FILL_COUNT - 1)));
    issue(mk(FUNC_BYINDEX, '0, '0));
    issue(mk(FUNC_FIND, ledger.dates[$urandom_range(FILL_COUNT - 1)], '0));
    issue(mk(FUNC_NEAREST, DATE_TOP, '0));
    issue(mk(FUNC_NEAREST, '0, '0));
    issue(mk(FUNC_NEAREST, DATE_W'($urandom), '0));
    issue(mk(FUNC_CLEAR, '0, '0));
    drain();

    for (p = 0; p < 4; p++) begin
      for (n = 0; n < PHASE_ITEMS; n++) begin
        issue(random_cmd());
        gap(idle_pct[p]);
        if ($urandom_range(99) == 0) drain();
      end
      drain();
    end

    repeat (NCELL + 8) @(posedge clk);
    if (ledger.faults == 0) $display("** sorted_date_table_search_top: PASSED **");
    else $display("** sorted_date_table_search_top: FAILED **");
    $finish;
  end

endmodule
